FILE: rtl/ertt_pkg.sv
// Shared types and constants for the echo request round-trip table.
package ertt_pkg;

  localparam int unsigned IdentW   = 16;
  localparam int unsigned SeqW     = 16;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned OpW      = 2;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned DivSteps   = TimeW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  typedef enum logic [OpW-1:0] {
    OP_RECORD   = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_QUERY    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IdentW-1:0] ident;
    logic [SeqW-1:0]   seq;
    logic [TimeW-1:0]  now;
  } cmd_t;

  typedef struct packed {
    logic              matched;
    logic              replied;
    logic [TimeW-1:0]  rtt;
  } rsp_t;

endpackage

FILE: rtl/ertt_front.sv
// Input stage: accepts stream transactions, decodes the operation, feeds the queue.
module ertt_front import ertt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,
  input  logic [OpW-1:0]     s_axis_tuser_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output cmd_t               push_cmd_o
);

  logic hold_q, hold_d;
  cmd_t cmd_q;
  logic accept;

  assign s_axis_tready_o = !hold_q || push_ready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_valid_o    = hold_q;
  assign push_cmd_o      = cmd_q;

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (push_ready_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op    <= op_e'(s_axis_tuser_i);
      cmd_q.ident <= s_axis_tdata_i[IdentW-1:0];
      cmd_q.seq   <= s_axis_tdata_i[IdentW+SeqW-1:IdentW];
      cmd_q.now   <= s_axis_tdata_i[IdentW+SeqW+TimeW-1:IdentW+SeqW];
    end
  end

endmodule

FILE: rtl/ertt_queue.sv
// Short command queue between the input stage and the table engine.
module ertt_queue import ertt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_pop_i,
  output cmd_t out_cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = cnt_q != CntW'(QueueDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_cmd_o   = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_pop_i && out_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

FILE: rtl/ertt_div.sv
// Radix-2 restoring divider: 64-bit dividend by 16-bit divisor, one bit per cycle.
module ertt_div import ertt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TimeW-1:0]  dividend_i,
  input  logic [TicksW-1:0] divisor_i,
  output logic              done_o,
  output logic [TimeW-1:0]  quotient_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [TimeW-1:0]   quo_q, quo_d;
  logic [TicksW-1:0]  rem_q, rem_d;
  logic [TicksW-1:0]  div_q;
  logic [TicksW:0]    trial;
  logic               fits;

  assign trial = {rem_q, quo_q[TimeW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d = fits ? TicksW'(trial - {1'b0, div_q}) : trial[TicksW-1:0];
    quo_d = {quo_q[TimeW-2:0], fits};
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= (divisor_i == '0) ? TicksW'(1) : divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

endmodule

FILE: rtl/ertt_back.sv
// Table engine: key match, record/complete/query/clear, result register.
module ertt_back import ertt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TicksW-1:0]   cfg_wdata_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  cmd_t                cmd_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output rsp_t                rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [IdentW-1:0] ident;
    logic [SeqW-1:0]   seq;
    logic [TimeW-1:0]  send;
    logic [TimeW-1:0]  rtt;
  } entry_t;

  state_e                   state_q;
  entry_t                   entry_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [TABLE_ENTRIES-1:0] replied_q;
  logic [TicksW-1:0]        ticks_q;
  logic [IdxW-1:0]          slot_q;
  logic                     rsp_valid_q;
  rsp_t                     rsp_q;

  logic            hit_any, hitu_any, free_any;
  logic [IdxW-1:0] hit_idx, hitu_idx, free_idx;
  logic            pop, div_start, div_done;
  logic [TimeW-1:0] div_quo;
  logic            rec_en, rec_shift;
  logic [IdxW-1:0] rec_idx;

  always_comb begin
    hit_any  = 1'b0;
    hitu_any = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    hitu_idx = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && entry_q[i].ident == cmd_i.ident && entry_q[i].seq == cmd_i.seq) begin
        hit_any = 1'b1;
        hit_idx = IdxW'(i);
        if (!replied_q[i]) begin
          hitu_any = 1'b1;
          hitu_idx = IdxW'(i);
        end
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign pop       = state_q == ST_IDLE && cmd_valid_i && (!rsp_valid_q || rsp_ready_i);
  assign cmd_pop_o = pop;
  assign div_start = pop && cmd_i.op == OP_COMPLETE && hitu_any;

  always_comb begin
    rec_en    = pop && cmd_i.op == OP_RECORD;
    rec_shift = rec_en && !hit_any && !free_any;
    rec_idx   = hit_any ? hit_idx : (free_any ? free_idx : IdxW'(TABLE_ENTRIES - 1));
  end

  ertt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.now - entry_q[hitu_idx].send),
    .divisor_i  (ticks_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      replied_q   <= '0;
      ticks_q     <= TicksW'(1);
      slot_q      <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            rsp_valid_q <= 1'b1;
            rsp_q       <= '0;
            case (cmd_i.op)
              OP_RECORD: begin
                rsp_q.matched <= hit_any;
                if (rec_shift) begin
                  for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
                    replied_q[i] <= replied_q[i+1];
                  end
                end
                valid_q[rec_idx]   <= 1'b1;
                replied_q[rec_idx] <= 1'b0;
              end
              OP_COMPLETE: begin
                if (hitu_any) begin
                  rsp_valid_q <= 1'b0;
                  slot_q      <= hitu_idx;
                  state_q     <= ST_DIV;
                end
              end
              OP_QUERY: begin
                if (hit_any) begin
                  rsp_q.matched <= 1'b1;
                  rsp_q.replied <= replied_q[hit_idx];
                  rsp_q.rtt     <= entry_q[hit_idx].rtt;
                end
              end
              OP_CLEAR: begin
                if (hit_any) begin
                  rsp_q.matched    <= 1'b1;
                  valid_q[hit_idx] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            replied_q[slot_q] <= 1'b1;
            rsp_valid_q       <= 1'b1;
            rsp_q.matched     <= 1'b1;
            rsp_q.replied     <= 1'b1;
            rsp_q.rtt         <= div_quo;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_en) begin
      if (rec_shift) begin
        for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
          entry_q[i] <= entry_q[i+1];
        end
      end
      entry_q[rec_idx].ident <= cmd_i.ident;
      entry_q[rec_idx].seq   <= cmd_i.seq;
      entry_q[rec_idx].send  <= cmd_i.now;
      entry_q[rec_idx].rtt   <= '0;
    end
    if (state_q == ST_DIV && div_done) begin
      entry_q[slot_q].rtt <= div_quo;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: rtl/echo_request_rtt_table_core.sv
// Echo request round-trip table, top level.
//
// Input stream: s_axis_tuser_i carries the operation (record, complete,
// query, clear); s_axis_tdata_i carries ident, seq and the timer value.
// Output stream: one result transaction per input transaction, in order,
// with the match flag, the replied flag and the round-trip time in us.
// cfg_we_i/cfg_wdata_i write ticks-per-microsecond (0 acts as 1); write
// only while no transaction is in flight.
//
// Record, query, clear and an unmatched complete pass through the input
// register, the queue and the result register. A matched complete also
// waits for the serial divider, which resolves one quotient bit per cycle
// over 64 bits.
// Throughput: one record/query/clear per cycle while the receiver takes
// results; a matched complete holds the engine until its division ends.
//
// Reset empties the table, the queue and the result register and sets
// ticks-per-microsecond to 1. When the receiver stalls, the result is
// held; the input stage and the two-entry queue keep taking up to three
// more transactions before s_axis_tready_o drops.
module echo_request_rtt_table_core import ertt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TicksW-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [15:0] ident, [31:16] seq, [95:32] now_ticks
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [1:0] operation
  input  logic [OpW-1:0]      s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] matched, [1] replied, [65:2] rtt_us, [71:66] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic push_valid, push_ready, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;
  rsp_t rsp;

  ertt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_cmd_o      (push_cmd)
  );

  ertt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_cmd_i    (push_cmd),
    .out_valid_o (q_valid),
    .out_pop_i   (q_pop),
    .out_cmd_o   (q_cmd)
  );

  ertt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (q_cmd),
    .rsp_valid_o (m_axis_tvalid_o),
    .rsp_ready_i (m_axis_tready_i),
    .rsp_o       (rsp)
  );

  assign m_axis_tdata_o = {(OutDataW - TimeW - 2)'(0), rsp.rtt, rsp.replied, rsp.matched};

endmodule

FILE: rtl/ertt_checker.sv
// Port-level checker for the echo request round-trip table, bound to the top level.
module ertt_checker import ertt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_replied_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[1] && !m_axis_tdata_o[0]))
    else $error("replied without match");

  a_rtt_only_when_replied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[1] |-> m_axis_tdata_o[OutDataW-1:2] == '0)
    else $error("nonzero time on unreplied result");

endmodule

bind echo_request_rtt_table_core ertt_checker u_ertt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
